/* hw/rtl/scs_pkg.sv */
// scs_pkg: shared constants and types for the sparse cosine similarity block
// used by scs_ctrl, scs_dp and sparse_cosine_similarity
`default_nettype none
package scs_pkg;
  localparam int MaxEntries = 1024;
  localparam int TermBits = 20;
  localparam int AddrBits = $clog2(MaxEntries);
  localparam int CntBits = $clog2(MaxEntries + 1);
  localparam int SumBits = 48;
  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

  localparam logic CmdLoadA = 1'b0;
  localparam logic CmdStreamB = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_a;      // store one A entry and accumulate its norm
    logic close_a;     // the A word carries last, close the load
    logic b_begin;     // latch a B word, start the cursor scan
    logic b_step;      // compare registered A entry against the B term
    logic fin_start;   // start the products and the cosine search
    logic fin_step;    // one iteration of the finishing unit
    logic clr_b;       // clear cursor and B sums after the result
  } scs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic b_done;      // cursor scan finished for the current B word
    logic fin_done;    // finishing unit has its answer
  } scs_sts_t;
endpackage
`default_nettype wire

/* hw/rtl/sparse_cosine_similarity.sv */
// sparse_cosine_similarity: top level joining controller and datapath
// depends on scs_pkg, scs_ctrl, scs_dp
// usage:
//   input words: command selects an A load (0) or a B stream word (1),
//   with term_index, weight and last; accepted when in_valid_i is high
//   and in_stall_o is low. A words may follow back to back.
//   a B word walks the stored A with a one-read-port memory cursor,
//   and the input stalls while the cursor scans past smaller A terms.
//   on a B word with last set, na*nb and dot*dot are formed on one 24x24
//   multiplier, then an exact 15-bit search runs one bit at a time; the
//   result word is then offered on out_valid_o and is held until
//   out_stall_i is low. an input can be taken again in the cycle after
//   the result is taken. no input is taken while a result waits.
//   reset empties A (count zero) and clears all sums; no clearing pass.
`default_nettype none
module sparse_cosine_similarity
  import scs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                command_i,
  input  wire logic [TermBits-1:0] term_index_i,
  input  wire logic [15:0]         weight_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [15:0]              cosine_o,
  output logic                     degenerate_o,
  output logic                     overflowed_o
);
  scs_cmd_t ctl;
  scs_sts_t sts;
  scs_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i(command_i),
    .last_i, .out_valid_o, .out_stall_i, .ctl_o(ctl), .sts_i(sts));
  scs_dp u_dp (.clk_i, .rst_ni, .cmd_i(ctl), .sts_o(sts), .term_i(term_index_i),
    .weight_i, .cosine_o, .degenerate_o, .overflowed_o);
endmodule
`default_nettype wire

/* hw/rtl/scs_dp.sv */
// scs_dp: A store, merge cursor, 48-bit sums and bit-serial cosine search
// depends on scs_pkg
`default_nettype none
module scs_dp
  import scs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire scs_cmd_t            cmd_i,
  output scs_sts_t                 sts_o,
  input  wire logic [TermBits-1:0] term_i,
  input  wire logic [15:0]         weight_i,
  output logic [15:0]              cosine_o,
  output logic                     degenerate_o,
  output logic                     overflowed_o
);
  logic [TermBits+15:0] mem_q [MaxEntries];
  logic [TermBits+15:0] rd_q;
  logic [CntBits-1:0] a_count_q, cursor_q;
  logic a_open_q, a_ovf_q;
  logic [SumBits-1:0] na_q, nb_q, dot_q;
  logic [TermBits-1:0] bterm_q;
  logic [15:0] bw_q;
  logic rd_ok_q;

  logic [31:0] wsq;
  assign wsq = 32'(weight_i) * 32'(weight_i);

  function automatic logic [SumBits-1:0] sat(input logic [SumBits-1:0] s,
                                             input logic [31:0] v);
    logic [SumBits:0] r;
    r = {1'b0, s} + (SumBits+1)'(v);
    return r[SumBits] ? SumMax : r[SumBits-1:0];
  endfunction

  logic [TermBits-1:0] a_term;
  logic [15:0] a_w;
  logic in_range;
  assign a_term = rd_q[TermBits+15:16];
  assign a_w = rd_q[15:0];
  assign in_range = (cursor_q < a_count_q);

  logic [AddrBits-1:0] wr_addr, rd_addr;
  logic fresh;
  assign fresh = !a_open_q;
  assign wr_addr = fresh ? '0 : a_count_q[AddrBits-1:0];
  logic [CntBits-1:0] rd_next;
  assign rd_addr = rd_next[AddrBits-1:0];

  logic match, adv, scan_end;
  assign match = rd_ok_q && in_range && a_term == bterm_q;
  assign adv = rd_ok_q && in_range && a_term < bterm_q;
  assign scan_end = cmd_i.b_step && !adv;

  always_comb begin
    rd_next = cursor_q;
    if (cmd_i.b_step && (adv || match)) rd_next = cursor_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && (fresh || a_count_q < CntBits'(MaxEntries)))
      mem_q[wr_addr] <= {term_i, weight_i};
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_count_q <= '0; a_open_q <= 1'b0; a_ovf_q <= 1'b0;
      cursor_q <= '0; rd_ok_q <= 1'b0;
      na_q <= '0; nb_q <= '0; dot_q <= '0;
    end else begin
      rd_ok_q <= 1'b0;
      if (cmd_i.load_a) begin
        cursor_q <= '0; dot_q <= '0; nb_q <= '0;
        if (fresh) begin
          a_count_q <= CntBits'(1); na_q <= SumBits'(wsq); a_ovf_q <= 1'b0;
        end else if (a_count_q < CntBits'(MaxEntries)) begin
          a_count_q <= a_count_q + 1'b1; na_q <= sat(na_q, wsq);
        end else begin
          a_ovf_q <= 1'b1;
        end
        a_open_q <= !cmd_i.close_a;
      end
      if (cmd_i.b_begin) begin
        a_open_q <= 1'b0; bterm_q <= term_i; bw_q <= weight_i;
        nb_q <= sat(nb_q, wsq); rd_ok_q <= 1'b1;
      end
      if (cmd_i.b_step) begin
        cursor_q <= rd_next;
        if (adv) rd_ok_q <= 1'b1;
        if (match) dot_q <= sat(dot_q, 32'(a_w) * 32'(bw_q));
      end
      if (cmd_i.clr_b) begin
        cursor_q <= '0; dot_q <= '0; nb_q <= '0;
      end
    end
  end

  // finishing unit: p = na*nb and d = dot*dot on one 24x24 multiplier,
  // then the largest q < 2^15 with q^2 * p <= d * 2^30, one bit per FinAdd, FinCmp pass
  typedef enum logic [2:0] {
    FinIdle, FinMulP, FinMulD, FinSetup, FinAdd, FinCmp, FinDone
  } fin_e;
  fin_e fin_q;
  logic [1:0]   mstep_q;
  logic [95:0]  prod_q, dd_q;
  logic [127:0] res_q, ps_q, t_q, s_q;
  logic [14:0]  q_q;
  logic [3:0]   qb_q;
  logic         full_q;

  logic [47:0] mul_a, mul_b, pp;
  logic [23:0] op_x, op_y;
  logic [95:0] pp_sh;
  assign mul_a = (fin_q == FinMulP) ? na_q : dot_q;
  assign mul_b = (fin_q == FinMulP) ? nb_q : dot_q;
  assign op_x = mstep_q[1] ? mul_a[47:24] : mul_a[23:0];
  assign op_y = mstep_q[0] ? mul_b[47:24] : mul_b[23:0];
  assign pp = 48'(op_x) * 48'(op_y);

  always_comb begin
    unique case (mstep_q)
      2'd0: pp_sh = 96'(pp);
      2'd3: pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  // res holds d*2^30 - q^2*p, t holds q*p << (b+1), ps holds p << 2b
  logic [128:0] diff;
  assign diff = {1'b0, res_q} - {1'b0, s_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= FinIdle; mstep_q <= '0; qb_q <= '0; q_q <= '0; full_q <= 1'b0;
    end else if (cmd_i.fin_start) begin
      fin_q <= FinMulP; mstep_q <= '0; prod_q <= '0; dd_q <= '0;
    end else if (cmd_i.fin_step) begin
      unique case (fin_q)
        FinMulP: begin
          prod_q <= prod_q + pp_sh; mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 2'd3) fin_q <= FinMulD;
        end
        FinMulD: begin
          dd_q <= dd_q + pp_sh; mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 2'd3) fin_q <= FinSetup;
        end
        FinSetup: begin
          res_q <= {2'b0, dd_q, 30'd0}; ps_q <= {4'b0, prod_q, 28'd0}; t_q <= '0;
          q_q <= '0; qb_q <= 4'd14; full_q <= dd_q >= prod_q; fin_q <= FinAdd;
        end
        FinAdd: begin
          s_q <= t_q + ps_q; fin_q <= FinCmp;
        end
        FinCmp: begin
          if (!diff[128]) begin
            res_q <= diff[127:0]; t_q <= (t_q >> 1) + ps_q;
            q_q <= q_q | (15'd1 << qb_q);
          end else begin
            t_q <= t_q >> 1;
          end
          ps_q <= ps_q >> 2;
          if (qb_q == 4'd0) fin_q <= FinDone;
          else begin
            qb_q <= qb_q - 1'b1; fin_q <= FinAdd;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.b_done = scan_end;
  assign sts_o.fin_done = fin_q == FinDone;
  assign degenerate_o = (na_q == '0) || (nb_q == '0);
  // dot^2 >= na*nb means the similarity reaches one
  assign cosine_o = degenerate_o ? 16'd0 : (full_q ? 16'd32768 : {1'b0, q_q});
  assign overflowed_o = a_ovf_q;

`ifndef SYNTHESIS
  a_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= a_count_q || cmd_i.load_a) else $error("cursor past count");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_count_q <= CntBits'(MaxEntries)) else $error("count over capacity");
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_b |=> cursor_q == '0) else $error("cursor not cleared");
`endif
endmodule
`default_nettype wire

/* hw/rtl/scs_ctrl.sv */
// scs_ctrl: sequencer for loads, merge scans and the finishing search
// depends on scs_pkg
`default_nettype none
module scs_ctrl
  import scs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     cmd_i,
  input  wire logic     last_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output scs_cmd_t      ctl_o,
  input  wire scs_sts_t sts_i
);
  typedef enum logic [1:0] {Idle, Scan, Fin, Hold} state_e;
  state_e state_q;
  logic last_q, go;
  assign in_stall_o = state_q != Idle;
  assign go = in_valid_i && state_q == Idle;

  always_comb begin
    ctl_o = '0;
    ctl_o.load_a = go && cmd_i == CmdLoadA;
    ctl_o.close_a = go && cmd_i == CmdLoadA && last_i;
    ctl_o.b_begin = go && cmd_i == CmdStreamB;
    ctl_o.b_step = state_q == Scan;
    ctl_o.fin_start = state_q == Scan && sts_i.b_done && last_q;
    ctl_o.fin_step = state_q == Fin;
    ctl_o.clr_b = state_q == Hold && !out_stall_i;
  end
  assign out_valid_o = state_q == Hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; last_q <= 1'b0;
    end else begin
      unique case (state_q)
        Idle: if (ctl_o.b_begin) begin state_q <= Scan; last_q <= last_i; end
        Scan: if (sts_i.b_done) state_q <= last_q ? Fin : Idle;
        Fin: if (sts_i.fin_done) state_q <= Hold;
        Hold: if (!out_stall_i) state_q <= Idle;
        default: state_q <= Idle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.load_a, ctl_o.b_begin, ctl_o.b_step})) else $error("cmd overlap");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result lost");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept during result");
`endif
endmodule
`default_nettype wire

/* dv/sparse_cosine_similarity_test.sv */
// sparse_cosine_similarity_test: self-checking bench for the sparse cosine similarity block
// depends on scs_pkg and sparse_cosine_similarity; predicts every score in the bench itself
`timescale 1ns / 100ps
`default_nettype none
module sparse_cosine_similarity_test;
  import scs_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int TailCycles = 400;
  localparam int RandomWords = 1850;
  localparam logic [TermBits-1:0] TermTop = {TermBits{1'b1}};

  typedef struct packed {
    logic [15:0] cosine;
    logic        degenerate;
    logic        overflowed;
  } score_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                command_i;
  logic [TermBits-1:0] term_index_i;
  logic [15:0]         weight_i;
  logic                last_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [15:0]         cosine_o;
  logic                degenerate_o;
  logic                overflowed_o;

  sparse_cosine_similarity u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .term_index_i(term_index_i),
    .weight_i    (weight_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cosine_o    (cosine_o),
    .degenerate_o(degenerate_o),
    .overflowed_o(overflowed_o)
  );

  // shadow copy of the block state
  logic [TermBits-1:0] stored_term[MaxEntries];
  logic [15:0]         stored_weight[MaxEntries];
  int                  stored_count;
  int                  join_cursor;
  bit                  a_loading;
  bit                  a_dropped;
  logic [SumBits-1:0]  norm_a;
  logic [SumBits-1:0]  norm_b;
  logic [SumBits-1:0]  dot_acc;

  score_t pending_scores[$];
  logic [TermBits-1:0] a_terms_sent[$];

  int  errors;
  int  cycles;
  int  words_sent;
  int  scores_seen;
  int  degenerate_seen;
  int  overflow_seen;
  bit  burst_mode;
  int  hold_cycles;
  int  recv_wait;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d scores outstanding", cycles,
               pending_scores.size());
      $display("** sparse_cosine_similarity: FAILED **");
      $finish;
    end
  end

  function automatic logic [SumBits-1:0] sat_sum(logic [SumBits-1:0] s, logic [63:0] v);
    logic [64:0] r;
    r = {17'b0, s} + {1'b0, v};
    return (r > {17'b0, SumMax}) ? SumMax : r[SumBits-1:0];
  endfunction

  // largest c <= 1.0 in Q1.15 with c^2 * na * nb <= dot^2 * 2^30
  function automatic logic [15:0] q15_cosine(logic [SumBits-1:0] dot,
                                             logic [SumBits-1:0] na,
                                             logic [SumBits-1:0] nb);
    logic [127:0] prod;
    logic [127:0] rhs;
    logic [127:0] lhs;
    int lo;
    int hi;
    int mid;
    prod = {80'b0, na} * {80'b0, nb};
    rhs = ({80'b0, dot} * {80'b0, dot}) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = prod * 128'(longint'(mid) * mid);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 16'(lo);
  endfunction

  task automatic predict_similarity(logic cmd, logic [TermBits-1:0] term, logic [15:0] w,
                                    logic last);
    score_t s;
    if (cmd == CmdLoadA) begin
      if (!a_loading) begin
        stored_count = 0;
        norm_a = '0;
        a_dropped = 1'b0;
        a_loading = 1'b1;
      end
      join_cursor = 0;
      dot_acc = '0;
      norm_b = '0;
      if (stored_count < MaxEntries) begin
        stored_term[stored_count] = term;
        stored_weight[stored_count] = w;
        stored_count++;
        norm_a = sat_sum(norm_a, 64'(w) * 64'(w));
      end else begin
        a_dropped = 1'b1;
      end
      if (last) a_loading = 1'b0;
      return;
    end
    a_loading = 1'b0;
    while (join_cursor < stored_count && stored_term[join_cursor] < term) join_cursor++;
    if (join_cursor < stored_count && stored_term[join_cursor] == term) begin
      dot_acc = sat_sum(dot_acc, 64'(stored_weight[join_cursor]) * 64'(w));
      join_cursor++;
    end
    norm_b = sat_sum(norm_b, 64'(w) * 64'(w));
    if (!last) return;
    if (norm_a == '0 || norm_b == '0) begin
      s.cosine = '0;
      s.degenerate = 1'b1;
    end else begin
      s.cosine = q15_cosine(dot_acc, norm_a, norm_b);
      s.degenerate = 1'b0;
    end
    s.overflowed = a_dropped;
    pending_scores = {pending_scores, s};
    join_cursor = 0;
    dot_acc = '0;
    norm_b = '0;
  endtask

  task automatic send_word(logic cmd, logic [TermBits-1:0] term, logic [15:0] w, logic last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    term_index_i <= term;
    weight_i <= w;
    last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_similarity(cmd, term, w, last);
    words_sent++;
  endtask

  task automatic wait_scores_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // ascending A vector with random spacing, records the terms it used in a_terms_sent
  task automatic load_vector_a(int len, bit close);
    int t;
    a_terms_sent.delete();
    t = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 900000);
    for (int i = 0; i < len; i++) begin
      if (t > int'(TermTop)) t = int'(TermTop);
      a_terms_sent = {a_terms_sent, TermBits'(t)};
      send_word(CmdLoadA, TermBits'(t), rand_weight(), close && (i == len - 1));
      t = t + 1 + $urandom_range(0, 3000);
    end
  endtask

  // ascending B vector (partly random terms when shuffled) that hits many stored terms and some in between
  task automatic stream_vector_b(int len, bit shuffled);
    int prev;
    int t;
    int k;
    prev = -1;
    for (int i = 0; i < len; i++) begin
      k = 0;
      while (k < a_terms_sent.size() && int'(a_terms_sent[k]) <= prev) k++;
      k = k + $urandom_range(0, 1);
      if (shuffled && $urandom_range(0, 3) == 0)
        t = $urandom_range(0, int'(TermTop));
      else if ($urandom_range(0, 9) < 6 && k < a_terms_sent.size())
        t = int'(a_terms_sent[k]);
      else
        t = prev + 1 + $urandom_range(0, 2500);
      if (t > int'(TermTop)) t = int'(TermTop);
      prev = t;
      send_word(CmdStreamB, TermBits'(t), rand_weight(), i == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    score_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scores_seen++;
      if (degenerate_o) degenerate_seen++;
      if (overflowed_o) overflow_seen++;
      if (pending_scores.size() == 0) begin
        $error("score word with nothing expected: cosine %0d", cosine_o);
        errors++;
      end else begin
        exp_s = pending_scores.pop_front();
        if (cosine_o !== exp_s.cosine) begin
          $error("cosine: expected %0d, got %0d", exp_s.cosine, cosine_o);
          errors++;
        end
        if (degenerate_o !== exp_s.degenerate) begin
          $error("degenerate: expected %0d, got %0d", exp_s.degenerate, degenerate_o);
          errors++;
        end
        if (overflowed_o !== exp_s.overflowed) begin
          $error("overflowed: expected %0d, got %0d", exp_s.overflowed, overflowed_o);
          errors++;
        end
      end
      recv_wait = burst_mode ? 0 : $urandom_range(0, 7);
    end
  end

  // receiver stall, a long hold takes priority over the per word wait
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (recv_wait > 0) begin
      out_stall_i <= 1'b1;
      recv_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic test_directed();
    // identical single entries give exactly one
    send_word(CmdLoadA, '0, 16'hffff, 1'b1);
    send_word(CmdStreamB, '0, 16'hffff, 1'b1);
    // zero weight on the B side
    send_word(CmdStreamB, '0, 16'h0000, 1'b1);
    // top term, no overlap then overlap
    send_word(CmdLoadA, 20'h00001, 16'h0100, 1'b0);
    send_word(CmdLoadA, TermTop, 16'h0001, 1'b1);
    send_word(CmdStreamB, 20'h00002, 16'h0100, 1'b1);
    send_word(CmdStreamB, TermTop, 16'hffff, 1'b1);
    // unsorted and repeated terms on B
    send_word(CmdStreamB, TermTop, 16'h0200, 1'b0);
    send_word(CmdStreamB, 20'h00001, 16'h0300, 1'b0);
    send_word(CmdStreamB, TermTop, 16'h0400, 1'b1);
    // all-zero A
    send_word(CmdLoadA, 20'h55555, 16'h0000, 1'b1);
    send_word(CmdStreamB, 20'h55555, 16'h1234, 1'b1);
    // B word cuts an open A load short, A is kept as it stands
    send_word(CmdLoadA, 20'haaaaa, 16'h0800, 1'b0);
    send_word(CmdStreamB, 20'haaaaa, 16'h0800, 1'b1);
    // partly streamed B abandoned by a new A entry
    send_word(CmdStreamB, 20'haaaaa, 16'h0700, 1'b0);
    send_word(CmdLoadA, 20'h0f0f0, 16'h00ff, 1'b1);
    send_word(CmdStreamB, 20'h0f0f0, 16'h8000, 1'b1);
    wait_scores_drained();
  endtask

  task automatic test_capacity_overflow();
    burst_mode = 1'b1;
    load_vector_a(MaxEntries + 4, 1'b1);
    burst_mode = 1'b0;
    stream_vector_b(20, 1'b0);
    stream_vector_b(6, 1'b0);
    // a fresh A clears the overflow flag
    load_vector_a(3, 1'b1);
    stream_vector_b(3, 1'b0);
    wait_scores_drained();
  endtask

  task automatic test_backpressure();
    load_vector_a(6, 1'b1);
    hold_cycles = 600;
    for (int i = 0; i < 4; i++) stream_vector_b($urandom_range(1, 4), 1'b0);
    wait_scores_drained();
  endtask

  task automatic test_random_pairs();
    while (words_sent < RandomWords) begin
      burst_mode = ($urandom_range(0, 11) == 0);
      case ($urandom_range(0, 9))
        0: begin
          // noise words
          repeat ($urandom_range(1, 6))
            send_word(1'($urandom), TermBits'($urandom), rand_weight(), 1'($urandom));
        end
        1: begin
          load_vector_a($urandom_range(1, 8), 1'b0);
          stream_vector_b($urandom_range(1, 8), 1'b1);
        end
        2: stream_vector_b($urandom_range(1, 12), 1'b0);
        default: begin
          load_vector_a($urandom_range(1, 16), 1'b1);
          repeat ($urandom_range(1, 3)) stream_vector_b($urandom_range(1, 16), 1'b0);
        end
      endcase
    end
    burst_mode = 1'b0;
    wait_scores_drained();
  endtask

  initial begin
    in_valid_i = 1'b0;
    command_i = CmdLoadA;
    term_index_i = '0;
    weight_i = '0;
    last_i = 1'b0;
    out_stall_i = 1'b0;
    rst_ni = 1'b0;
    errors = 0;
    cycles = 0;
    words_sent = 0;
    scores_seen = 0;
    degenerate_seen = 0;
    overflow_seen = 0;
    burst_mode = 1'b0;
    hold_cycles = 0;
    recv_wait = 0;
    stored_count = 0;
    join_cursor = 0;
    a_loading = 1'b0;
    a_dropped = 1'b0;
    norm_a = '0;
    norm_b = '0;
    dot_acc = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_capacity_overflow();
    test_backpressure();
    test_random_pairs();

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d input words and %0d scores (%0d degenerate, %0d with A overflow)",
             words_sent, scores_seen, degenerate_seen, overflow_seen);
    $display("including full A capacity, long output hold-off and broken vector sequences");
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("** sparse_cosine_similarity: PASSED **");
    end else begin
      $display("** sparse_cosine_similarity: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
